>>> rtl/u8u16_pkg.sv
// Shared types, constants and helpers for the UTF-8 to UTF-16 decoder.
// Used by every module under rtl and by the port checker. No dependencies.
`default_nettype none

package u8u16_pkg;

  localparam int DATA_W          = 8;
  localparam int UNIT_W          = 16;
  localparam int UNIT_TOTAL_W    = 20;
  localparam int POINT_W         = 21;
  localparam int KIND_W          = 2;
  localparam int TDATA_IN_W      = 8;
  localparam int TDATA_OUT_W     = 40;
  localparam int MAX_RESULTS     = 3;
  localparam int COUNT_WIDTH_DEF = 20;

  localparam logic [DATA_W-1:0] ASCII_MAX  = 8'h7f;
  localparam logic [DATA_W-1:0] LEAD2_LO   = 8'hc2;
  localparam logic [DATA_W-1:0] LEAD2_HI   = 8'hdf;
  localparam logic [DATA_W-1:0] LEAD3_E0   = 8'he0;
  localparam logic [DATA_W-1:0] LEAD3_LO   = 8'he1;
  localparam logic [DATA_W-1:0] LEAD3_HI   = 8'hec;
  localparam logic [DATA_W-1:0] LEAD3_ED   = 8'hed;
  localparam logic [DATA_W-1:0] LEAD3_EE   = 8'hee;
  localparam logic [DATA_W-1:0] LEAD3_EF   = 8'hef;
  localparam logic [DATA_W-1:0] LEAD4_F0   = 8'hf0;
  localparam logic [DATA_W-1:0] LEAD4_LO   = 8'hf1;
  localparam logic [DATA_W-1:0] LEAD4_HI   = 8'hf3;
  localparam logic [DATA_W-1:0] LEAD4_F4   = 8'hf4;
  localparam logic [DATA_W-1:0] CONT_MASK  = 8'hc0;
  localparam logic [DATA_W-1:0] CONT_TAG   = 8'h80;
  localparam logic [DATA_W-1:0] CONT_LO    = 8'h80;
  localparam logic [DATA_W-1:0] CONT_HI    = 8'hbf;
  localparam logic [DATA_W-1:0] SEC_8F     = 8'h8f;
  localparam logic [DATA_W-1:0] SEC_90     = 8'h90;
  localparam logic [DATA_W-1:0] SEC_9F     = 8'h9f;
  localparam logic [DATA_W-1:0] SEC_A0     = 8'ha0;

  localparam logic [POINT_W-1:0] BMP_MAX     = 21'h00ffff;
  localparam logic [POINT_W-1:0] SUPP_BASE   = 21'h010000;
  localparam logic [UNIT_W-1:0]  SUR_HI_BASE = 16'hd800;
  localparam logic [UNIT_W-1:0]  SUR_LO_BASE = 16'hdc00;
  localparam logic [UNIT_TOTAL_W-1:0] TOTAL_MAX = 20'hfffff;

  typedef enum logic [KIND_W-1:0] {
    KIND_UNIT   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  // Allowed range of the second byte of a sequence
  typedef enum logic [2:0] {
    CLS_ANY  = 3'd0,  // 80-BF
    CLS_A0BF = 3'd1,
    CLS_809F = 3'd2,
    CLS_90BF = 3'd3,
    CLS_808F = 3'd4
  } sec_cls_e;

  typedef struct packed {
    kind_e                   kind;
    logic [UNIT_W-1:0]       code_unit;
    logic [UNIT_TOTAL_W-1:0] unit_total;
    logic                    ascii_only;
    logic                    last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0]                   cnt;
    result_t [MAX_RESULTS-1:0]    res;
  } bundle_t;

  function automatic logic second_ok(sec_cls_e cls, logic [DATA_W-1:0] b);
    logic r;
    unique case (cls)
      CLS_A0BF: r = (b >= SEC_A0) && (b <= CONT_HI);
      CLS_809F: r = (b >= CONT_LO) && (b <= SEC_9F);
      CLS_90BF: r = (b >= SEC_90) && (b <= CONT_HI);
      CLS_808F: r = (b >= CONT_LO) && (b <= SEC_8F);
      default:  r = (b & CONT_MASK) == CONT_TAG;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/u8u16_decode.sv
// Sequence state registers and the per-byte decode into a bundle of results.
// Depends on u8u16_pkg.
`default_nettype none

module u8u16_decode
  import u8u16_pkg::*;
#(
  parameter int CountWidth = COUNT_WIDTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [DATA_W-1:0] byte_i,
  input  wire logic              eos_i,
  output bundle_t                bundle_o
);

  localparam int WideW = (CountWidth > UNIT_TOTAL_W) ? CountWidth : UNIT_TOTAL_W;

  logic [POINT_W-1:0]    point_q, point_d;
  logic [1:0]            left_q, left_d;
  sec_cls_e              cls_q, cls_d;
  logic                  second_q, second_d;
  logic                  failed_q, failed_d;
  logic                  ascii_q, ascii_d;
  logic [CountWidth-1:0] units_q, units_d;

  logic [1:0]            n_units;
  logic [UNIT_W-1:0]     unit0, unit1;
  logic [POINT_W-1:0]    cp;
  logic [19:0]           adj;
  logic                  seq_ok;
  logic [CountWidth:0]   units_sum;
  logic [CountWidth-1:0] units_new;
  logic [WideW-1:0]      units_wide;
  logic                  str_fail;
  result_t               status, r0, r1;

  always_comb begin
    point_d  = point_q;
    left_d   = left_q;
    cls_d    = cls_q;
    second_d = second_q;
    failed_d = failed_q;
    n_units  = 2'd0;
    unit0    = '0;
    unit1    = '0;
    cp       = {point_q[POINT_W-7:0], byte_i[5:0]};
    adj      = 20'(cp - SUPP_BASE);
    seq_ok   = 1'b0;

    if (!failed_q) begin
      if (left_q == 2'd0) begin
        priority if (byte_i <= ASCII_MAX) begin
          n_units = 2'd1;
          unit0   = UNIT_W'(byte_i);
        end else if (byte_i >= LEAD2_LO && byte_i <= LEAD2_HI) begin
          left_d = 2'd1; cls_d = CLS_ANY; second_d = 1'b1;
          point_d = POINT_W'(byte_i[4:0]);
        end else if (byte_i == LEAD3_E0) begin
          left_d = 2'd2; cls_d = CLS_A0BF; second_d = 1'b1; point_d = '0;
        end else if ((byte_i >= LEAD3_LO && byte_i <= LEAD3_HI) ||
                     byte_i == LEAD3_EE || byte_i == LEAD3_EF) begin
          left_d = 2'd2; cls_d = CLS_ANY; second_d = 1'b1;
          point_d = POINT_W'(byte_i[3:0]);
        end else if (byte_i == LEAD3_ED) begin
          left_d = 2'd2; cls_d = CLS_809F; second_d = 1'b1;
          point_d = POINT_W'(byte_i[3:0]);
        end else if (byte_i == LEAD4_F0) begin
          left_d = 2'd3; cls_d = CLS_90BF; second_d = 1'b1; point_d = '0;
        end else if (byte_i >= LEAD4_LO && byte_i <= LEAD4_HI) begin
          left_d = 2'd3; cls_d = CLS_ANY; second_d = 1'b1;
          point_d = POINT_W'(byte_i[2:0]);
        end else if (byte_i == LEAD4_F4) begin
          left_d = 2'd3; cls_d = CLS_808F; second_d = 1'b1;
          point_d = POINT_W'(byte_i[2:0]);
        end else begin
          failed_d = 1'b1;
        end
      end else begin
        seq_ok = second_q ? second_ok(cls_q, byte_i) : ((byte_i & CONT_MASK) == CONT_TAG);
        if (!seq_ok) begin
          failed_d = 1'b1;
        end else begin
          second_d = 1'b0;
          cls_d    = CLS_ANY;
          point_d  = cp;
          left_d   = left_q - 2'd1;
          if (left_q == 2'd1) begin
            point_d = '0;
            if (cp <= BMP_MAX) begin
              n_units = 2'd1;
              unit0   = cp[UNIT_W-1:0];
            end else begin
              n_units = 2'd2;
              unit0   = SUR_HI_BASE + UNIT_W'(adj[19:10]);
              unit1   = SUR_LO_BASE + UNIT_W'(adj[9:0]);
            end
          end
        end
      end
    end

    ascii_d = ascii_q & ~((n_units != 2'd0) && (unit0 > UNIT_W'(ASCII_MAX)))
                      & ~((n_units == 2'd2) && (unit1 > UNIT_W'(ASCII_MAX)));

    // Saturating count: the carry out means the sum passed all ones
    units_sum = {1'b0, units_q} + (CountWidth + 1)'(n_units);
    units_new = units_sum[CountWidth] ? '1 : units_sum[CountWidth-1:0];
    units_d   = units_new;
    units_wide = WideW'(units_new);

    str_fail = failed_d | (left_d != 2'd0);
    status.code_unit   = '0;
    status.last_of_run = 1'b1;
    if (str_fail) begin
      status.kind       = KIND_REJECT;
      status.unit_total = '0;
      status.ascii_only = 1'b0;
    end else begin
      status.kind       = KIND_ACCEPT;
      status.unit_total = (units_wide > WideW'(TOTAL_MAX)) ? TOTAL_MAX
                                                           : units_wide[UNIT_TOTAL_W-1:0];
      status.ascii_only = ascii_d;
    end

    r0 = '{kind: KIND_UNIT, code_unit: unit0, unit_total: '0, ascii_only: 1'b0,
           last_of_run: (n_units == 2'd1) && !eos_i};
    r1 = '{kind: KIND_UNIT, code_unit: unit1, unit_total: '0, ascii_only: 1'b0,
           last_of_run: !eos_i};

    // Pack units first, then the status
    bundle_o.cnt    = n_units + 2'(eos_i);
    bundle_o.res[0] = (n_units != 2'd0) ? r0 : status;
    bundle_o.res[1] = (n_units == 2'd2) ? r1 : status;
    bundle_o.res[2] = status;

    if (eos_i) begin
      point_d  = '0;
      left_d   = 2'd0;
      cls_d    = CLS_ANY;
      second_d = 1'b0;
      failed_d = 1'b0;
      ascii_d  = 1'b1;
      units_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_q  <= '0;
      left_q   <= 2'd0;
      cls_q    <= CLS_ANY;
      second_q <= 1'b0;
      failed_q <= 1'b0;
      ascii_q  <= 1'b1;
      units_q  <= '0;
    end else if (accept_i) begin
      point_q  <= point_d;
      left_q   <= left_d;
      cls_q    <= cls_d;
      second_q <= second_d;
      failed_q <= failed_d;
      ascii_q  <= ascii_d;
      units_q  <= units_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/u8u16_emit.sv
// Result register: holds up to three results from one byte, sends one a cycle while they are taken.
// Depends on u8u16_pkg.
`default_nettype none

module u8u16_emit
  import u8u16_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire bundle_t bundle_i,
  output logic         ready_o,
  output logic         valid_o,
  input  wire logic    take_i,
  output result_t      res_o
);

  logic [1:0]                cnt_q, cnt_d;
  result_t [MAX_RESULTS-1:0] res_q, res_d;
  logic                      pop;

  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o & take_i;
  // Free next cycle if empty or the last held result leaves now
  assign ready_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && take_i);
  assign res_o   = res_q[0];

  always_comb begin
    cnt_d = cnt_q;
    res_d = res_q;
    if (pop) begin
      cnt_d    = cnt_q - 2'd1;
      res_d[0] = res_q[1];
      res_d[1] = res_q[2];
    end
    if (load_i) begin
      cnt_d = bundle_i.cnt;
      res_d = bundle_i.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

`default_nettype wire

>>> rtl/utf8_to_utf16_validating_decoder.sv
// A byte's results are registered in the output register on its transfer.
// Throughput: one byte a cycle while the output is taken; a byte that yields
// two or three results (a surrogate pair plus a status) holds the input until
// the one-result-per-cycle output register is down to its last result.
// Reset (rst_ni low, asynchronous): string state clears, output empties.
// Depends on u8u16_pkg, u8u16_decode and u8u16_emit.
`default_nettype none

module utf8_to_utf16_validating_decoder
  import u8u16_pkg::*;
#(
  parameter int CountWidth = COUNT_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Byte stream in
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [TDATA_IN_W-1:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic                   s_axis_tlast,   // end_of_string
  // UTF-16 units and string status out
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0]      m_axis_tdata,   // [15:0] code_unit,
                                                      // [35:16] unit_total,
                                                      // [36] ascii_only, rest 0
  output logic [KIND_W-1:0]           m_axis_tuser,   // [1:0] kind
  output logic                        m_axis_tlast    // last_of_run
);

  logic    in_xfer;
  logic    emit_ready;
  bundle_t bundle;
  result_t res;

  // A byte transfers whenever the output register will be free next cycle,
  // so a byte that yields nothing or one result stalls the stream only under back-pressure.
  assign s_axis_tready = emit_ready;
  assign in_xfer       = s_axis_tvalid & s_axis_tready;

  // Decode: advance the sequence state and build this byte's results.
  u8u16_decode #(
    .CountWidth(CountWidth)
  ) u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_xfer),
    .byte_i   (s_axis_tdata[DATA_W-1:0]),
    .eos_i    (s_axis_tlast),
    .bundle_o (bundle)
  );

  // Output register: hold the bundle and drain it one transfer at a time.
  u8u16_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (in_xfer),
    .bundle_i (bundle),
    .ready_o  (emit_ready),
    .valid_o  (m_axis_tvalid),
    .take_i   (m_axis_tready),
    .res_o    (res)
  );

  assign m_axis_tdata = TDATA_OUT_W'({res.ascii_only, res.unit_total, res.code_unit});
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last_of_run;

endmodule

`default_nettype wire

>>> rtl/u8u16_checker.sv
// Port-level checker for the decoder, bound to the top level.
// Depends on u8u16_pkg and utf8_to_utf16_validating_decoder.
`default_nettype none

module u8u16_checker
  import u8u16_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [TDATA_OUT_W-1:0] m_axis_tdata,
  input wire logic [KIND_W-1:0]      m_axis_tuser,
  input wire logic                   m_axis_tlast
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output result changed while stalled");

  // Every status closes its byte's run and carries no code unit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_UNIT |->
      m_axis_tlast && m_axis_tdata[UNIT_W-1:0] == '0)
    else $error("status without last mark or with a code unit");

  // A rejected status reports no count and no ASCII flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_REJECT |->
      m_axis_tdata[TDATA_OUT_W-1:UNIT_W] == '0)
    else $error("rejected status carries a count");

  // A high surrogate is always followed directly by its low half
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_UNIT &&
      m_axis_tdata[15:10] == 6'b110110 |->
      !m_axis_tlast ##1 (m_axis_tvalid && m_axis_tuser == KIND_UNIT &&
                         m_axis_tdata[15:10] == 6'b110111))
    else $error("high surrogate not followed by low surrogate");

  // Code units carry no count and no ASCII flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_UNIT |->
      m_axis_tdata[TDATA_OUT_W-1:UNIT_W] == '0)
    else $error("code unit carries status fields");

endmodule

bind utf8_to_utf16_validating_decoder u8u16_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
